>>> hdl/sft_pkg.sv
// Shared constants and rounding helpers for the surface frame transform.
package sft_pkg;

   localparam int REQ_W      = 208;
   localparam int RSP_W      = 256;
   localparam int POINT_W    = 32;
   localparam int NRM_W      = 16;
   localparam int SIZE_W     = 16;
   localparam int ANG_W      = 16;
   localparam int COL_W      = 17;

   localparam int NORM_IN_W  = 32;
   localparam int MAG_W      = 31;
   localparam int NORM_TOP   = 29;
   localparam int SUM_W      = 62;
   localparam int ROOT_W     = 31;

   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_W     = 34;
   localparam int CORDIC_FRAC  = 30;
   localparam int TWO_PI_W     = 33;
   localparam longint TWO_PI_Q30      = 64'sd6746518852;
   localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

   localparam longint ATAN_Q30 [10] = '{
      64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159, 64'sd67021687,
      64'sd33543516,  64'sd16775851,  64'sd8388437,   64'sd4194283,   64'sd2097149
   };

   localparam longint COL_MAX = 64'sd65535;
   localparam longint COL_MIN = -64'sd65536;

   function automatic longint atan_at(input int i);
      longint res;
      if (i < 10) begin
         res = ATAN_Q30[i];
      end else begin
         res = longint'(1) <<< (CORDIC_FRAC - i);
      end
      return res;
   endfunction

   function automatic longint rnd_shr(input longint v, input int sh);
      longint half;
      longint res;
      if (sh == 0) begin
         res = v;
      end else begin
         half = longint'(1) <<< (sh - 1);
         if (v >= 0) begin
            res = (v + half) >>> sh;
         end else begin
            res = -((-v + half) >>> sh);
         end
      end
      return res;
   endfunction

   function automatic longint clamp_unit(input longint v, input int frac);
      longint one;
      longint res;
      one = longint'(1) <<< frac;
      if (v > one) begin
         res = one;
      end else if (v < -one) begin
         res = -one;
      end else begin
         res = v;
      end
      return res;
   endfunction

   function automatic logic signed [COL_W-1:0] sat_col(input longint v);
      logic signed [COL_W-1:0] res;
      if (v > COL_MAX) begin
         res = COL_W'(COL_MAX);
      end else if (v < COL_MIN) begin
         res = COL_W'(COL_MIN);
      end else begin
         res = COL_W'(v);
      end
      return res;
   endfunction

endpackage

>>> hdl/sft_cordic.sv
// Pipelined cosine and sine of a binary angle, one CORDIC step per stage.
module sft_cordic
   import sft_pkg::*;
#(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC       = 14,
   parameter int SIDE_W     = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [ANG_W-1:0]         in_angle,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic signed [FRAC+1:0]   out_cos,
   output logic signed [FRAC+1:0]   out_sin,
   output logic [SIDE_W-1:0]        out_side
);
   localparam int OW     = FRAC + 2;
   localparam int REM_W  = ANGLE_BITS - 2;
   localparam int PROD_W = REM_W + TWO_PI_W;

   logic [ANGLE_BITS-1:0] ang;
   logic                  v0_ff;
   logic [1:0]            quad0_ff;
   logic [PROD_W-1:0]     prod0_ff;
   logic [SIDE_W-1:0]     side0_ff;

   logic                       v_ff    [0:CORDIC_STEPS];
   logic [1:0]                 quad_ff [0:CORDIC_STEPS];
   logic [SIDE_W-1:0]          side_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] x_ff    [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] y_ff    [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] z_ff    [0:CORDIC_STEPS];

   logic signed [OW-1:0] c_q, s_q, cos_in, sin_in;
   logic                 out_valid_ff;
   logic signed [OW-1:0] cos_ff, sin_ff;
   logic [SIDE_W-1:0]    oside_ff;

   assign ang = ANGLE_BITS'(in_angle);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
      if (en) begin
         quad0_ff <= ang[ANGLE_BITS-1 -: 2];
         prod0_ff <= PROD_W'(ang[REM_W-1:0]) * PROD_W'(TWO_PI_Q30);
         side0_ff <= in_side;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= v0_ff;
      end
      if (en) begin
         quad_ff[0] <= quad0_ff;
         side_ff[0] <= side0_ff;
         x_ff[0]    <= CORDIC_W'(CORDIC_GAIN_Q30);
         y_ff[0]    <= '0;
         z_ff[0]    <= CORDIC_W'((prod0_ff + (PROD_W'(1) << (ANGLE_BITS - 1))) >> ANGLE_BITS);
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      localparam longint AT = atan_at(i);
      logic signed [CORDIC_W-1:0] dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (en) begin
            quad_ff[i+1] <= quad_ff[i];
            side_ff[i+1] <= side_ff[i];
            if (!z_ff[i][CORDIC_W-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - CORDIC_W'(AT);
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + CORDIC_W'(AT);
            end
         end
      end
   end

   always_comb begin
      c_q = OW'(clamp_unit(rnd_shr(longint'(x_ff[CORDIC_STEPS]), CORDIC_FRAC - FRAC), FRAC));
      s_q = OW'(clamp_unit(rnd_shr(longint'(y_ff[CORDIC_STEPS]), CORDIC_FRAC - FRAC), FRAC));
      case (quad_ff[CORDIC_STEPS])
         2'd0: begin
            cos_in = c_q;
            sin_in = s_q;
         end
         2'd1: begin
            cos_in = -s_q;
            sin_in = c_q;
         end
         2'd2: begin
            cos_in = -c_q;
            sin_in = -s_q;
         end
         default: begin
            cos_in = s_q;
            sin_in = -c_q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= v_ff[CORDIC_STEPS];
      end
      if (en) begin
         cos_ff   <= cos_in;
         sin_ff   <= sin_in;
         oside_ff <= side_ff[CORDIC_STEPS];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
   assign out_side  = oside_ff;

endmodule

>>> hdl/sft_norm3.sv
// Pipelined 3-vector normalize: range shift, square root and three dividers.
module sft_norm3
   import sft_pkg::*;
#(
   parameter int FRAC   = 14,
   parameter int SIDE_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [2:0][NORM_IN_W-1:0] in_c,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_valid,
   output logic [2:0][FRAC+1:0]      out_r,
   output logic [SIDE_W-1:0]         out_side
);
   localparam int OW    = FRAC + 2;
   localparam int QN    = FRAC + 1;
   localparam int NW    = MAG_W + FRAC + 1;
   localparam int DC_W  = SIDE_W + 4;
   localparam int CAR_W = DC_W + 3 * MAG_W;
   localparam int REM_W = ROOT_W + 2;

   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic [2:0][MAG_W-1:0] mag0_in, mag0_ff, mag1_ff, mag2_ff, mag3_in, mag3_ff, mag4_ff;
   logic [2:0]            neg0_in, neg0_ff, neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [SIDE_W-1:0]     side0_ff, side1_ff, side2_ff, side3_ff, side4_ff;
   logic [MAG_W-1:0]      m1_in, m1_ff;
   logic [4:0]            hp, k2_in, k2_ff;
   logic                  zero2_ff, zero3_ff, zero4_ff;
   logic [2:0][2*MAG_W-1:0] sq4_ff;

   logic              sv_ff   [0:ROOT_W];
   logic [SUM_W-1:0]  sum_ff  [0:ROOT_W];
   logic [REM_W-1:0]  rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0] root_ff [0:ROOT_W];
   logic [CAR_W-1:0]  car_ff  [0:ROOT_W];

   logic                  dv_ff   [0:QN];
   logic [2:0][MAG_W-1:0] r_ff    [0:QN];
   logic [2:0][QN-1:0]    lo_ff   [0:QN];
   logic [2:0][QN-1:0]    q_ff    [0:QN];
   logic [ROOT_W-1:0]     s_ff    [0:QN];
   logic [DC_W-1:0]       dcar_ff [0:QN];

   logic [2:0][MAG_W-1:0] nmag;
   logic [2:0][NW-1:0]    num_in;
   logic [2:0][OW-1:0]    res_in, res_ff;
   logic                  ov_ff;
   logic [SIDE_W-1:0]     oside_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         neg0_in[l] = in_c[l][NORM_IN_W-1];
         mag0_in[l] = neg0_in[l] ? MAG_W'(-$signed(in_c[l])) : MAG_W'(in_c[l]);
      end
   end

   always_comb begin
      m1_in = mag0_ff[0];
      if (mag0_ff[1] > m1_in) m1_in = mag0_ff[1];
      if (mag0_ff[2] > m1_in) m1_in = mag0_ff[2];
   end

   always_comb begin
      hp = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (m1_ff[b]) hp = 5'(b);
      end
      k2_in = (hp >= 5'(NORM_TOP)) ? '0 : 5'(NORM_TOP) - hp;
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mag3_in[l] = mag2_ff[l] << k2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (en) begin
         mag0_ff  <= mag0_in;
         neg0_ff  <= neg0_in;
         side0_ff <= in_side;
         mag1_ff  <= mag0_ff;
         neg1_ff  <= neg0_ff;
         side1_ff <= side0_ff;
         m1_ff    <= m1_in;
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
         side2_ff <= side1_ff;
         k2_ff    <= k2_in;
         zero2_ff <= (m1_ff == '0);
         mag3_ff  <= mag3_in;
         neg3_ff  <= neg2_ff;
         side3_ff <= side2_ff;
         zero3_ff <= zero2_ff;
         for (int l = 0; l < 3; l++) begin
            sq4_ff[l] <= (2*MAG_W)'(mag3_ff[l]) * (2*MAG_W)'(mag3_ff[l]);
         end
         mag4_ff  <= mag3_ff;
         neg4_ff  <= neg3_ff;
         side4_ff <= side3_ff;
         zero4_ff <= zero3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= v4_ff;
      end
      if (en) begin
         sum_ff[0]  <= SUM_W'(sq4_ff[0]) + SUM_W'(sq4_ff[1]) + SUM_W'(sq4_ff[2]);
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         car_ff[0]  <= {side4_ff, neg4_ff, zero4_ff, mag4_ff};
      end
   end

   for (genvar t = 0; t < ROOT_W; t++) begin : g_root
      logic [REM_W+1:0] rem2, trial;
      assign rem2  = {rem_ff[t], sum_ff[t][SUM_W-1 -: 2]};
      assign trial = {1'b0, root_ff[t], 2'b01};
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[t+1] <= 1'b0;
         end else if (en) begin
            sv_ff[t+1] <= sv_ff[t];
         end
         if (en) begin
            sum_ff[t+1] <= sum_ff[t] << 2;
            car_ff[t+1] <= car_ff[t];
            if (rem2 >= trial) begin
               rem_ff[t+1]  <= REM_W'(rem2 - trial);
               root_ff[t+1] <= ROOT_W'({root_ff[t], 1'b1});
            end else begin
               rem_ff[t+1]  <= REM_W'(rem2);
               root_ff[t+1] <= ROOT_W'({root_ff[t], 1'b0});
            end
         end
      end
   end

   assign nmag = car_ff[ROOT_W][3*MAG_W-1:0];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         num_in[l] = NW'({nmag[l], {FRAC{1'b0}}}) + NW'(root_ff[ROOT_W] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= sv_ff[ROOT_W];
      end
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            r_ff[0][l]  <= num_in[l][NW-1:QN];
            lo_ff[0][l] <= num_in[l][QN-1:0];
         end
         q_ff[0]    <= '0;
         s_ff[0]    <= root_ff[ROOT_W];
         dcar_ff[0] <= car_ff[ROOT_W][CAR_W-1:3*MAG_W];
      end
   end

   for (genvar d = 0; d < QN; d++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[d+1] <= 1'b0;
         end else if (en) begin
            dv_ff[d+1] <= dv_ff[d];
         end
         if (en) begin
            s_ff[d+1]    <= s_ff[d];
            dcar_ff[d+1] <= dcar_ff[d];
            for (int l = 0; l < 3; l++) begin
               lo_ff[d+1][l] <= lo_ff[d][l] << 1;
               if ({r_ff[d][l], lo_ff[d][l][QN-1]} >= {1'b0, s_ff[d]}) begin
                  r_ff[d+1][l] <= MAG_W'({r_ff[d][l], lo_ff[d][l][QN-1]} - {1'b0, s_ff[d]});
                  q_ff[d+1][l] <= QN'({q_ff[d][l], 1'b1});
               end else begin
                  r_ff[d+1][l] <= MAG_W'({r_ff[d][l], lo_ff[d][l][QN-1]});
                  q_ff[d+1][l] <= QN'({q_ff[d][l], 1'b0});
               end
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (dcar_ff[QN][0]) begin
            res_in[l] = '0;
         end else begin
            res_in[l] = OW'(clamp_unit(longint'(q_ff[QN][l]), FRAC));
            if (dcar_ff[QN][l+1]) res_in[l] = OW'(-$signed(res_in[l]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= dv_ff[QN];
      end
      if (en) begin
         res_ff   <= res_in;
         oside_ff <= dcar_ff[QN][DC_W-1:4];
      end
   end

   assign out_valid = ov_ff;
   assign out_r     = res_ff;
   assign out_side  = oside_ff;

endmodule

>>> hdl/surface_frame_transform_top.sv
// Top level: tangent frame from a surface normal, rotated and scaled into matrix columns.
//
//  channel | dir | handshake             | beat content
//  --------+-----+-----------------------+-------------------------------------------
//  req     | in  | req_tvalid/req_tready | point x/y/z, normal x/y/z, angle, sizes
//  rsp     | out | rsp_tvalid/rsp_tready | u, v, n columns (Q8.8), translation (Q16.16)
//
//  One beat per cycle while rsp is not stalled; the pipeline holds the 30-step CORDIC,
//  two square-root chains of 31 stages and two UNIT_FRAC_BITS+1 step dividers.
//  Reset clears only the valid bits of the stages.
//  A stall at rsp freezes the whole pipeline; req_tready is low only while the
//  output register holds a beat that is not taken.
module surface_frame_transform_top
   import sft_pkg::*;
#(
   parameter int ANGLE_BITS     = 16,
   parameter int UNIT_FRAC_BITS = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // point_x, point_y, point_z, normal_x, normal_y, normal_z, angle, width, height, thickness
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // col_u_x/y/z, col_v_x/y/z, col_n_x/y/z, trans_x, trans_y, trans_z, zero fill
   output logic [RSP_W-1:0] rsp_tdata
);
   localparam int F  = UNIT_FRAC_BITS;
   localparam int OW = F + 2;
   localparam int PW = 2 * OW;
   localparam int CW = OW + SIZE_W + 1;
   localparam longint ONE = longint'(1) <<< F;

   typedef struct packed {
      logic [2:0][SIZE_W-1:0]  size;
      logic [2:0][POINT_W-1:0] point;
   } pass_type;

   typedef struct packed {
      pass_type               pass;
      logic [2:0][NRM_W-1:0]  normal;
   } cside_type;

   typedef struct packed {
      pass_type        pass;
      logic [OW-1:0]   co;
      logic [OW-1:0]   si;
   } n1side_type;

   typedef struct packed {
      pass_type             pass;
      logic [OW-1:0]        co;
      logic [OW-1:0]        si;
      logic [2:0][OW-1:0]   ax;
   } n2side_type;

   logic en;
   cside_type cd_side_in, cd_side;
   logic cd_valid;
   logic signed [OW-1:0] cd_co, cd_si;

   logic [2:0][NORM_IN_W-1:0] n1_c, n2_c;
   n1side_type n1_side_in, n1_side;
   n2side_type n2_side_in, n2_side;
   logic n1_valid, n2_valid;
   logic [2:0][OW-1:0] n1_r, n2_r;

   logic tv_ff;
   logic [2:0][OW-1:0] tax_ff, ttr_ff, ttr_in;
   n1side_type tside_ff;
   longint ay_abs;

   logic xv_ff;
   logic [5:0][PW-1:0] xp_ff;
   logic [2:0][OW-1:0] xt_ff;
   n2side_type xs_ff;

   logic bv_ff;
   logic [2:0][OW-1:0] bb_ff, bb_in, bt_ff;
   n2side_type bs_ff;

   logic rv_ff;
   logic [2:0][PW-1:0] rtc_ff, rbs_ff, rbc_ff, rts_ff;
   logic [2:0][OW-1:0] rax_ff;
   pass_type rpass_ff;

   logic uv_ff;
   logic [2:0][OW-1:0] uu_ff, uvv_ff, uax_ff, uu_in, uvv_in;
   pass_type upass_ff;

   logic cv_ff;
   logic [2:0][CW-1:0] cpu_ff, cpv_ff, cpn_ff;
   logic [2:0][POINT_W-1:0] cpoint_ff;

   logic [8:0][COL_W-1:0] cols_in;
   logic rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   assign cd_side_in.pass.point = req_tdata[95:0];
   assign cd_side_in.normal     = req_tdata[143:96];
   assign cd_side_in.pass.size  = req_tdata[207:160];

   sft_cordic #(
      .ANGLE_BITS (ANGLE_BITS),
      .FRAC       (F),
      .SIDE_W     ($bits(cside_type))
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_angle  (req_tdata[159:144]),
      .in_side   (cd_side_in),
      .out_valid (cd_valid),
      .out_cos   (cd_co),
      .out_sin   (cd_si),
      .out_side  (cd_side)
   );

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         n1_c[l] = NORM_IN_W'($signed(cd_side.normal[l]));
      end
      n1_side_in.pass = cd_side.pass;
      n1_side_in.co   = cd_co;
      n1_side_in.si   = cd_si;
   end

   sft_norm3 #(
      .FRAC   (F),
      .SIDE_W ($bits(n1side_type))
   ) u_norm_axis (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cd_valid),
      .in_c      (n1_c),
      .in_side   (n1_side_in),
      .out_valid (n1_valid),
      .out_r     (n1_r),
      .out_side  (n1_side)
   );

   always_comb begin
      ay_abs = longint'($signed(n1_r[1]));
      if (ay_abs < 0) ay_abs = -ay_abs;
      if (ay_abs * 100 > (longint'(99) <<< F)) begin
         ttr_in[0] = OW'(-$signed(n1_r[1]));
         ttr_in[1] = n1_r[0];
         ttr_in[2] = '0;
      end else begin
         ttr_in[0] = n1_r[2];
         ttr_in[1] = '0;
         ttr_in[2] = OW'(-$signed(n1_r[0]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= 1'b0;
      end else if (en) begin
         tv_ff <= n1_valid;
      end
      if (en) begin
         tax_ff   <= n1_r;
         ttr_ff   <= ttr_in;
         tside_ff <= n1_side;
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         n2_c[l] = NORM_IN_W'($signed(ttr_ff[l]));
      end
      n2_side_in.pass = tside_ff.pass;
      n2_side_in.co   = tside_ff.co;
      n2_side_in.si   = tside_ff.si;
      n2_side_in.ax   = tax_ff;
   end

   sft_norm3 #(
      .FRAC   (F),
      .SIDE_W ($bits(n2side_type))
   ) u_norm_tangent (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (tv_ff),
      .in_c      (n2_c),
      .in_side   (n2_side_in),
      .out_valid (n2_valid),
      .out_r     (n2_r),
      .out_side  (n2_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         xv_ff <= 1'b0;
      end else if (en) begin
         xv_ff <= n2_valid;
      end
      if (en) begin
         xp_ff[0] <= $signed(n2_side.ax[1]) * $signed(n2_r[2]);
         xp_ff[1] <= $signed(n2_side.ax[2]) * $signed(n2_r[1]);
         xp_ff[2] <= $signed(n2_side.ax[2]) * $signed(n2_r[0]);
         xp_ff[3] <= $signed(n2_side.ax[0]) * $signed(n2_r[2]);
         xp_ff[4] <= $signed(n2_side.ax[0]) * $signed(n2_r[1]);
         xp_ff[5] <= $signed(n2_side.ax[1]) * $signed(n2_r[0]);
         xt_ff    <= n2_r;
         xs_ff    <= n2_side;
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         bb_in[l] = OW'(clamp_unit(rnd_shr(longint'($signed(xp_ff[2*l]))
                                          - longint'($signed(xp_ff[2*l+1])), F), F));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= 1'b0;
      end else if (en) begin
         bv_ff <= xv_ff;
      end
      if (en) begin
         bb_ff <= bb_in;
         bt_ff <= xt_ff;
         bs_ff <= xs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (en) begin
         rv_ff <= bv_ff;
      end
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            rtc_ff[l] <= $signed(bt_ff[l]) * $signed(bs_ff.co);
            rbs_ff[l] <= $signed(bb_ff[l]) * $signed(bs_ff.si);
            rbc_ff[l] <= $signed(bb_ff[l]) * $signed(bs_ff.co);
            rts_ff[l] <= $signed(bt_ff[l]) * $signed(bs_ff.si);
         end
         rax_ff   <= bs_ff.ax;
         rpass_ff <= bs_ff.pass;
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         uu_in[l]  = OW'(clamp_unit(rnd_shr(longint'($signed(rtc_ff[l]))
                                           + longint'($signed(rbs_ff[l])), F), F));
         uvv_in[l] = OW'(clamp_unit(rnd_shr(longint'($signed(rbc_ff[l]))
                                           - longint'($signed(rts_ff[l])), F), F));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uv_ff <= 1'b0;
      end else if (en) begin
         uv_ff <= rv_ff;
      end
      if (en) begin
         uu_ff    <= uu_in;
         uvv_ff   <= uvv_in;
         uax_ff   <= rax_ff;
         upass_ff <= rpass_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= 1'b0;
      end else if (en) begin
         cv_ff <= uv_ff;
      end
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            cpu_ff[l] <= $signed(uu_ff[l])  * $signed({1'b0, upass_ff.size[0]});
            cpv_ff[l] <= $signed(uvv_ff[l]) * $signed({1'b0, upass_ff.size[1]});
            cpn_ff[l] <= $signed(uax_ff[l]) * $signed({1'b0, upass_ff.size[2]});
         end
         cpoint_ff <= upass_ff.point;
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         cols_in[l]   = sat_col(rnd_shr(longint'($signed(cpu_ff[l])), F));
         cols_in[3+l] = sat_col(rnd_shr(longint'($signed(cpv_ff[l])), F));
         cols_in[6+l] = sat_col(rnd_shr(longint'($signed(cpn_ff[l])), F));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= cv_ff;
      end
      if (en) begin
         rsp_data_ff <= RSP_W'({cpoint_ff, cols_in});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_trig_bound: assert property (@(posedge clock) disable iff (reset)
      cd_valid |-> (longint'(cd_co) <= ONE && longint'(cd_co) >= -ONE &&
                    longint'(cd_si) <= ONE && longint'(cd_si) >= -ONE))
      else $error("cos or sin beyond unit range");

   a_zero_axis: assert property (@(posedge clock) disable iff (reset)
      (n2_valid && n2_side.ax == '0) |-> n2_r == '0)
      else $error("zero axis gave nonzero tangent");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!en && n2_valid) |=> (n2_valid && $stable(n2_r)))
      else $error("tangent stage moved during stall");

endmodule

>>> tb/surface_frame_transform_top_chk.sv
// Checker: watches both channels, predicts each frame and compares it with the response.
module surface_frame_transform_top_chk
   import sft_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               fail_count,
   output int               pending
);

   localparam int UFB = 14;
   localparam int ABITS = 16;

   logic [RSP_W-1:0] frame_q[$];

   function automatic longint frac_rnd(longint v);
      longint h;
      h = longint'(1) <<< (UFB - 1);
      if (v >= 0) return (v + h) >>> UFB;
      return -((-v + h) >>> UFB);
   endfunction

   function automatic longint unit_clip(longint v);
      longint one;
      one = longint'(1) <<< UFB;
      if (v > one) return one;
      if (v < -one) return -one;
      return v;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic void unit_vec(input longint c[3], output longint r[3]);
      longint unsigned mag[3], m, sum, s, q;
      int k;
      m = 0;
      sum = 0;
      k = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = c[i] < 0 ? -c[i] : c[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         r[0] = 0; r[1] = 0; r[2] = 0;
         return;
      end
      while ((m << k) < (64'd1 << 29)) k++;
      for (int i = 0; i < 3; i++) begin
         mag[i] <<= k;
         sum += mag[i] * mag[i];
      end
      s = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << UFB) + (s >> 1)) / s;
         r[i] = unit_clip(c[i] < 0 ? -longint'(q) : longint'(q));
      end
   endfunction

   function automatic longint floor_shr(longint v, int sh);
      return v >>> sh;
   endfunction

   function automatic void rot_terms(input logic [15:0] ang, output longint co,
                                     output longint si);
      longint unsigned a, rem;
      int quad;
      longint x, y, z, dx, dy, at, c, s;
      a = ang & ((64'd1 << ABITS) - 1);
      quad = int'((a >> (ABITS - 2)) & 3);
      rem = a & ((64'd1 << (ABITS - 2)) - 1);
      z = longint'((rem * 64'd6746518852 + (64'd1 << (ABITS - 1))) >> ABITS);
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         at = (i < 10) ? ATAN_Q30[i] : (longint'(1) <<< (30 - i));
         if (z >= 0) begin
            x -= dx; y += dy; z -= at;
         end else begin
            x += dx; y -= dy; z += at;
         end
      end
      c = (x >= 0) ? (x + (1 <<< 15)) >>> 16 : -((-x + (1 <<< 15)) >>> 16);
      s = (y >= 0) ? (y + (1 <<< 15)) >>> 16 : -((-y + (1 <<< 15)) >>> 16);
      c = unit_clip(c);
      s = unit_clip(s);
      case (quad)
         0: begin co = c; si = s; end
         1: begin co = -s; si = c; end
         2: begin co = -c; si = -s; end
         default: begin co = s; si = -c; end
      endcase
   endfunction

   function automatic logic [16:0] col_sat(longint v);
      if (v > 65535) return 17'h0FFFF;
      if (v < -65536) return 17'h10000;
      return v[16:0];
   endfunction

   function automatic logic [RSP_W-1:0] frame_of(logic [REQ_W-1:0] d);
      longint n[3], ax[3], tr[3], t[3], b[3], co, si, ay, u, v, w, h, th;
      logic [RSP_W-1:0] r;
      r = '0;
      for (int i = 0; i < 3; i++) n[i] = longint'($signed(d[96 + 16*i +: 16]));
      w = d[160 +: 16];
      h = d[176 +: 16];
      th = d[192 +: 16];
      unit_vec(n, ax);
      ay = ax[1] < 0 ? -ax[1] : ax[1];
      if (ay * 100 > 99 * (longint'(1) <<< UFB)) begin
         tr[0] = -ax[1]; tr[1] = ax[0]; tr[2] = 0;
      end else begin
         tr[0] = ax[2]; tr[1] = 0; tr[2] = -ax[0];
      end
      unit_vec(tr, t);
      b[0] = unit_clip(frac_rnd(ax[1] * t[2] - ax[2] * t[1]));
      b[1] = unit_clip(frac_rnd(ax[2] * t[0] - ax[0] * t[2]));
      b[2] = unit_clip(frac_rnd(ax[0] * t[1] - ax[1] * t[0]));
      rot_terms(d[144 +: 16], co, si);
      for (int i = 0; i < 3; i++) begin
         u = unit_clip(frac_rnd(t[i] * co + b[i] * si));
         v = unit_clip(frac_rnd(b[i] * co - t[i] * si));
         r[17*i +: 17] = col_sat(frac_rnd(u * w));
         r[51 + 17*i +: 17] = col_sat(frac_rnd(v * h));
         r[102 + 17*i +: 17] = col_sat(frac_rnd(ax[i] * th));
         r[153 + 32*i +: 32] = d[32*i +: 32];
      end
      return r;
   endfunction

   assign pending = frame_q.size();

   always @(posedge clock) begin
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) frame_q.push_back(frame_of(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (frame_q.size() == 0) begin
               $display("%0t: response beat with nothing expected, got %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               if (frame_q[0] !== rsp_tdata) begin
                  for (int i = 0; i < 9; i++)
                     if (frame_q[0][17*i +: 17] !== rsp_tdata[17*i +: 17])
                        $display("%0t: column field %0d expected %h got %h", $time, i,
                           frame_q[0][17*i +: 17], rsp_tdata[17*i +: 17]);
                  for (int i = 0; i < 3; i++)
                     if (frame_q[0][153 + 32*i +: 32] !== rsp_tdata[153 + 32*i +: 32])
                        $display("%0t: translation %0d expected %h got %h", $time, i,
                           frame_q[0][153 + 32*i +: 32], rsp_tdata[153 + 32*i +: 32]);
                  if (frame_q[0][255:249] !== rsp_tdata[255:249])
                     $display("%0t: fill expected %h got %h", $time,
                        frame_q[0][255:249], rsp_tdata[255:249]);
                  fail_count <= fail_count + 1;
               end
               void'(frame_q.pop_front());
            end
         end
      end
   end

endmodule

>>> tb/surface_frame_transform_top_tb.sv
// Testbench top: drives request beats with random bursts, stalls responses, gives the verdict.
module surface_frame_transform_top_tb
   import sft_pkg::*;
;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   int               fail_count;
   int               pending;
   logic             hold_off;
   logic             send_done;

   surface_frame_transform_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   surface_frame_transform_top_chk u_chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic logic [15:0] pick_nrm();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 4)) - 16'd2;
         3: return 16'h4000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [REQ_W-1:0] rand_beat();
      logic [REQ_W-1:0] d;
      d[95:0] = {$urandom, $urandom, $urandom};
      d[111:96] = pick_nrm();
      d[127:112] = pick_nrm();
      d[143:128] = pick_nrm();
      if ($urandom_range(0, 3) == 0) d[111:96] = 16'($urandom_range(0, 40));
      d[207:144] = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) d[207:160] = {3{16'hFFFF}};
      return d;
   endfunction

   function automatic logic [REQ_W-1:0] fixed_beat(int k);
      logic [REQ_W-1:0] d;
      d = '0;
      case (k)
         0: d = '0;
         1: d = '1;
         2: d = {{3{16'hFFFF}}, 16'h0000, 16'h0000, 16'h4000, 16'h0000, {3{32'h7FFFFFFF}}};
         3: d = {{3{16'hFFFF}}, 16'h4000, 16'h0000, 16'h0000, 16'h0000, {3{32'h80000000}}};
         4: d = {{3{16'h0100}}, 16'hC000, 16'h0000, 16'h7FFF, 16'h0000, 96'h0};
         5: d = {{3{16'hFFFF}}, 16'h8000, 16'h0000, 16'h8000, 16'h0000, 96'h1};
         6: d = {{3{16'hFFFF}}, 16'h2000, 16'h0100, 16'h4000, 16'h0000, 96'h2};
         7: d = {{3{16'hFFFF}}, 16'h3FFF, 16'h0000, 16'h0000, 16'h8000, 96'h3};
         8: d = {{3{16'hFFFF}}, 16'h0000, 16'h8000, 16'h0000, 16'h8000, 96'h4};
         9: d = {{3{16'hFFFF}}, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 96'h5};
         10: d = {{3{16'h8000}}, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 96'h6};
         11: d = {48'h0, 16'h1234, 16'h4000, 16'h0000, 16'h0000, 96'h7};
         12: d = {{3{16'hFFFF}}, 16'h0000, 16'h0000, 16'h0000, 16'h1234, 96'h8};
         default: d = rand_beat();
      endcase
      return d;
   endfunction

   initial begin
      int sent;
      int burst;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      send_done = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      sent = 0;
      while (sent < 420) begin
         burst = $urandom_range(1, 30);
         while (burst > 0 && sent < 420) begin
            req_tvalid <= 1;
            req_tdata <= (sent < 20) ? fixed_beat(sent) : rand_beat();
            @(posedge clock);
            while (!req_tready) @(posedge clock);
            sent++;
            burst--;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      req_tvalid <= 0;
      send_done <= 1;
   end

   initial begin
      hold_off = 0;
      wait (!reset);
      repeat (60) @(posedge clock);
      hold_off = 1;
      repeat (400) @(posedge clock);
      hold_off = 0;
   end

   initial begin
      int phase;
      rsp_tready = 0;
      phase = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         phase++;
         if (hold_off) rsp_tready <= 0;
         else if ((phase / 200) % 2 == 0) rsp_tready <= 1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   initial begin
      wait (send_done);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("surface_frame_transform_top_tb: PASS");
      end else begin
         $display("surface_frame_transform_top_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("surface_frame_transform_top_tb: FAIL");
      $finish;
   end

endmodule

>>> sim.f
hdl/sft_pkg.sv
hdl/sft_cordic.sv
hdl/sft_norm3.sv
hdl/surface_frame_transform_top.sv
tb/surface_frame_transform_top_chk.sv
tb/surface_frame_transform_top_tb.sv
